@@ hdl/gravity_particle_update_top_macros.svh @@
// assertion macros for the gravity particle update block
// expects clk_i and rst_ni in the scope of each use
`ifndef GRAVITY_PARTICLE_UPDATE_TOP_MACROS_SVH
`define GRAVITY_PARTICLE_UPDATE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GPU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define GPU_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define GPU_ASSERT(lbl, prop, msg)
`define GPU_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

@@ hdl/gpu_pkg.sv @@
// shared widths, item types, codes and fixed-point helpers
// for the gravity particle update block; no dependencies
package gpu_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned MagW     = WordBits + 1;
  localparam int unsigned ProdW    = 2 * MagW;
  localparam int unsigned NumW     = 2 * WordBits + FracBits;
  localparam int unsigned RootW    = ProdW / 2;
  localparam int unsigned MulCntW  = $clog2(MagW);
  localparam int unsigned DivCntW  = $clog2(NumW);
  localparam int unsigned RootCntW = $clog2(RootW);
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [WordBits-2:0] UMax = '1;

  typedef enum logic [1:0] {
    REQ_LOAD     = 2'd0,
    REQ_INTERACT = 2'd1,
    REQ_ADVANCE  = 2'd2
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRAV     = 3'd0,
    CFG_MIN_DIST = 3'd1,
    CFG_BOUND_X  = 3'd2,
    CFG_BOUND_Y  = 3'd3,
    CFG_BOUND_Z  = 3'd4
  } cfg_e;

  typedef struct packed {
    logic [1:0]                 req_type;
    logic signed [WordBits-1:0] src_x;
    logic signed [WordBits-1:0] src_y;
    logic signed [WordBits-1:0] src_z;
    logic signed [WordBits-1:0] load_vx;
    logic signed [WordBits-1:0] load_vy;
    logic signed [WordBits-1:0] load_vz;
    logic [WordBits-2:0]        src_mass;
    logic [WordBits-2:0]        step_time;
  } gpu_in_t;

  typedef struct packed {
    logic signed [WordBits-1:0] pos_out_x;
    logic signed [WordBits-1:0] pos_out_y;
    logic signed [WordBits-1:0] pos_out_z;
    logic signed [WordBits-1:0] vel_out_x;
    logic signed [WordBits-1:0] vel_out_y;
    logic signed [WordBits-1:0] vel_out_z;
    logic signed [WordBits-1:0] react_x;
    logic signed [WordBits-1:0] react_y;
    logic signed [WordBits-1:0] react_z;
    logic [WordBits-2:0]        pair_distance;
  } gpu_out_t;

  typedef struct packed {
    logic            start;
    logic [MagW-1:0] a;
    logic [MagW-1:0] b;
  } gpu_mul_req_t;

  typedef struct packed {
    logic             start;
    logic [NumW-1:0]  num;
    logic [ProdW-1:0] den;
  } gpu_div_req_t;

  // magnitude limited to the signed word range of the given sign
  function automatic logic [WordBits-1:0] sat_lim(input logic neg, input logic [NumW-1:0] m);
    logic [NumW-1:0] lim;
    lim = neg ? (NumW'(1) << (WordBits - 1)) : ((NumW'(1) << (WordBits - 1)) - NumW'(1));
    return (m > lim) ? lim[WordBits-1:0] : m[WordBits-1:0];
  endfunction

  // one-bit-grown signed value back into the word range
  function automatic logic [WordBits-1:0] clampw(input logic signed [WordBits:0] v);
    logic [WordBits-1:0] r;
    if (v[WordBits] != v[WordBits-1]) begin
      r = v[WordBits] ? {1'b1, {(WordBits-1){1'b0}}} : {1'b0, {(WordBits-1){1'b1}}};
    end else begin
      r = v[WordBits-1:0];
    end
    return r;
  endfunction

  function automatic logic [WordBits-1:0] absw(input logic signed [WordBits-1:0] v);
    return v[WordBits-1] ? WordBits'(-v) : WordBits'(v);
  endfunction

endpackage

@@ hdl/gpu_if.sv @@
// valid/ready channel interfaces for the input and result items
// depends on gpu_pkg for the payload types
interface gpu_in_if import gpu_pkg::*; ();
  logic    valid;
  logic    ready;
  gpu_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gpu_out_if import gpu_pkg::*; ();
  logic     valid;
  logic     ready;
  gpu_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/gpu_mul.sv @@
// serial shift-add multiplier, one multiplier bit per cycle
// depends on gpu_pkg for widths and the request struct
module gpu_mul import gpu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gpu_mul_req_t       req_i,
  output logic               done_o,
  output logic [ProdW-1:0]   prod_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [MulCntW-1:0] cnt_q, cnt_d;
  logic [MagW-1:0]    a_q, a_d;
  logic [ProdW-1:0]   p_q, p_d;
  logic [MagW:0]      sum;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    p_d    = p_q;
    sum    = {1'b0, p_q[ProdW-1:MagW]} + (p_q[0] ? {1'b0, a_q} : '0);
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = req_i.a;
      p_d    = {{MagW{1'b0}}, req_i.b};
    end else if (busy_q) begin
      p_d   = {sum, p_q[MagW-1:1]};
      cnt_d = cnt_q + MulCntW'(1);
      if (cnt_q == MulCntW'(MagW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    p_q <= p_d;
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

@@ hdl/gpu_div.sv @@
// serial restoring divider, one quotient bit per cycle
// depends on gpu_pkg for widths and the request struct
module gpu_div import gpu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gpu_div_req_t       req_i,
  output logic               done_o,
  output logic [NumW-1:0]    quot_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [ProdW-1:0]   den_q, den_d;
  logic [ProdW:0]     r_q, r_d;
  logic [NumW-1:0]    n_q, n_d;
  logic [ProdW:0]     r2;
  logic               ge;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    den_d  = den_q;
    r_d    = r_q;
    n_d    = n_q;
    r2     = {r_q[ProdW-1:0], n_q[NumW-1]};
    ge     = (r2 >= {1'b0, den_q});
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      den_d  = req_i.den;
      r_d    = '0;
      n_d    = req_i.num;
    end else if (busy_q) begin
      r_d   = ge ? (r2 - {1'b0, den_q}) : r2;
      n_d   = {n_q[NumW-2:0], ge};
      cnt_d = cnt_q + DivCntW'(1);
      if (cnt_q == DivCntW'(NumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    r_q   <= r_d;
    n_q   <= n_d;
  end

  assign done_o = done_q;
  assign quot_o = n_q;

endmodule

@@ hdl/gravity_particle_update_top.sv @@
// Gravity update for one particle in Q16.16. An item takes a variable number of
// cycles, all set by a one-bit-per-cycle multiplier, a one-bit-per-cycle divider
// and a two-bit-per-cycle square root: load and the unused code go straight to
// the result, advance takes six products, interact five products, the root, five
// quotients and six more products, plus any cycles that the finished item waits
// while the previous result is still held. One item is in work at a time; a
// result waits in the output register while the next item is accepted.
// depends on gpu_pkg, gpu_if, gpu_mul, gpu_div and the macros header
`include "gravity_particle_update_top_macros.svh"

module gravity_particle_update_top import gpu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  gpu_in_if.sink              in_i,
  gpu_out_if.source           out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [WordBits-1:0] cfg_data_i
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SQ   = 9'b000000010,
    S_ROOT = 9'b000000100,
    S_FNUM = 9'b000001000,
    S_FDIV = 9'b000010000,
    S_UDIV = 9'b000100000,
    S_QMUL = 9'b001000000,
    S_ADV  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_e;

  state_e                state_q, state_d;
  logic                  issued_q, issued_d;
  logic [1:0]            ax_q, ax_d;
  logic                  ph_q, ph_d;
  logic [RootCntW-1:0]   rcnt_q, rcnt_d;

  logic [WordBits-1:0]   pos_q [3], pos_d [3];
  logic [WordBits-1:0]   vel_q [3], vel_d [3];
  logic [WordBits-1:0]   acc_q [3], acc_d [3];
  logic [WordBits-2:0]   mass_q, mass_d;

  logic [WordBits-1:0]   g_q, g_d;
  logic [WordBits-2:0]   mind_q, mind_d;
  logic [WordBits-2:0]   bnd_q [3], bnd_d [3];

  logic                  dneg_q [3], dneg_d [3];
  logic [WordBits-1:0]   dmag_q [3], dmag_d [3];
  logic [WordBits-2:0]   srcm_q, srcm_d;
  logic [WordBits-2:0]   t_q, t_d;
  logic [ProdW-1:0]      s_q, s_d;
  logic [ProdW-1:0]      ssh_q, ssh_d;
  logic [RootW+1:0]      rem_q, rem_d;
  logic [RootW-1:0]      root_q, root_d;
  logic [ProdW-1:0]      nown_q, nown_d;
  logic [ProdW-1:0]      nsrc_q, nsrc_d;
  logic [WordBits-1:0]   fown_q, fown_d;
  logic [WordBits-1:0]   fsrc_q, fsrc_d;
  logic [WordBits-1:0]   umag_q [3], umag_d [3];
  logic [WordBits-1:0]   react_q [3], react_d [3];
  logic [WordBits-2:0]   dist_q, dist_d;

  gpu_out_t              res_q, res_d;
  logic                  res_vld_q, res_vld_d;

  gpu_mul_req_t          mul_req;
  logic                  mul_done;
  logic [ProdW-1:0]      mul_prod;
  gpu_div_req_t          div_req;
  logic                  div_done;
  logic [NumW-1:0]       div_quot;

  logic [WordBits-1:0]   src_arr [3];
  logic [WordBits-1:0]   lv_arr [3];
  logic signed [WordBits:0] dsum [3];
  logic [ProdW-1:0]      smin;
  logic [ProdW-1:0]      s_sum;
  logic [RootW+1:0]      rem2;
  logic [RootW+1:0]      trial;
  logic                  gneg;
  logic                  qneg;
  logic [WordBits-1:0]   qmag;
  logic signed [WordBits:0] qval;
  logic [WordBits-1:0]   vel_new;
  logic [WordBits-1:0]   pos_new;
  logic                  accept;

  gpu_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  gpu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign in_i.ready  = (state_q == S_IDLE);
  assign accept      = in_i.valid && in_i.ready;
  assign out_o.valid = res_vld_q;
  assign out_o.data  = res_q;

  assign src_arr[0] = in_i.data.src_x;
  assign src_arr[1] = in_i.data.src_y;
  assign src_arr[2] = in_i.data.src_z;
  assign lv_arr[0]  = in_i.data.load_vx;
  assign lv_arr[1]  = in_i.data.load_vy;
  assign lv_arr[2]  = in_i.data.load_vz;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dsum[k] = $signed({src_arr[k][WordBits-1], src_arr[k]})
              - $signed({pos_q[k][WordBits-1], pos_q[k]});
    end
  end

  assign gneg  = g_q[WordBits-1];
  assign smin  = ProdW'({((mind_q == '0) ? (WordBits-1)'(1) : mind_q), FracBits'(0)});
  assign s_sum = s_q + mul_prod;
  assign rem2  = {rem_q[RootW-1:0], ssh_q[ProdW-1 -: 2]};
  assign trial = {root_q, 2'b01};

  // sign of the scaled product that finishes this cycle
  always_comb begin
    qneg = 1'b0;
    if (state_q == S_QMUL) begin
      qneg = gneg ^ dneg_q[ax_q];
    end else if (state_q == S_ADV) begin
      qneg = ph_q ? vel_q[ax_q][WordBits-1] : acc_q[ax_q][WordBits-1];
    end
  end

  assign qmag    = sat_lim(qneg, NumW'(mul_prod >> FracBits));
  assign qval    = qneg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  assign vel_new = clampw($signed({vel_q[ax_q][WordBits-1], vel_q[ax_q]}) + qval);
  assign pos_new = clampw($signed({pos_q[ax_q][WordBits-1], pos_q[ax_q]}) + qval);

  always_comb begin
    state_d   = state_q;
    issued_d  = issued_q;
    ax_d      = ax_q;
    ph_d      = ph_q;
    rcnt_d    = rcnt_q;
    pos_d     = pos_q;
    vel_d     = vel_q;
    acc_d     = acc_q;
    mass_d    = mass_q;
    g_d       = g_q;
    mind_d    = mind_q;
    bnd_d     = bnd_q;
    dneg_d    = dneg_q;
    dmag_d    = dmag_q;
    srcm_d    = srcm_q;
    t_d       = t_q;
    s_d       = s_q;
    ssh_d     = ssh_q;
    rem_d     = rem_q;
    root_d    = root_q;
    nown_d    = nown_q;
    nsrc_d    = nsrc_q;
    fown_d    = fown_q;
    fsrc_d    = fsrc_q;
    umag_d    = umag_q;
    react_d   = react_q;
    dist_d    = dist_q;
    res_d     = res_q;
    res_vld_d = res_vld_q && !out_o.ready;
    mul_req   = '0;
    div_req   = '0;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRAV:     g_d      = cfg_data_i;
        CFG_MIN_DIST: mind_d   = cfg_data_i[WordBits-2:0];
        CFG_BOUND_X:  bnd_d[0] = cfg_data_i[WordBits-2:0];
        CFG_BOUND_Y:  bnd_d[1] = cfg_data_i[WordBits-2:0];
        CFG_BOUND_Z:  bnd_d[2] = cfg_data_i[WordBits-2:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          issued_d = 1'b0;
          ax_d     = '0;
          ph_d     = 1'b0;
          dist_d   = '0;
          for (int k = 0; k < 3; k++) begin
            react_d[k] = '0;
          end
          case (in_i.data.req_type)
            REQ_LOAD: begin
              for (int k = 0; k < 3; k++) begin
                pos_d[k] = src_arr[k];
                vel_d[k] = lv_arr[k];
                acc_d[k] = '0;
              end
              mass_d  = in_i.data.src_mass;
              state_d = S_DONE;
            end
            REQ_INTERACT: begin
              for (int k = 0; k < 3; k++) begin
                dneg_d[k] = dsum[k][WordBits];
                dmag_d[k] = dsum[k][WordBits] ? WordBits'(-dsum[k]) : WordBits'(dsum[k]);
              end
              srcm_d  = in_i.data.src_mass;
              s_d     = '0;
              state_d = S_SQ;
            end
            REQ_ADVANCE: begin
              t_d     = in_i.data.step_time;
              state_d = S_ADV;
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      S_SQ: begin
        mul_req.start = !issued_q;
        mul_req.a     = MagW'(dmag_q[ax_q]);
        mul_req.b     = MagW'(dmag_q[ax_q]);
        issued_d      = 1'b1;
        if (issued_q && mul_done) begin
          issued_d = 1'b0;
          if (ax_q == 2'd2) begin
            // clamp the squared distance before the root
            s_d     = (s_sum < smin) ? smin : s_sum;
            ssh_d   = (s_sum < smin) ? smin : s_sum;
            rem_d   = '0;
            root_d  = '0;
            rcnt_d  = '0;
            ax_d    = '0;
            state_d = S_ROOT;
          end else begin
            s_d  = s_sum;
            ax_d = ax_q + 2'd1;
          end
        end
      end

      S_ROOT: begin
        ssh_d  = ssh_q << 2;
        rcnt_d = rcnt_q + RootCntW'(1);
        if (rem2 >= trial) begin
          rem_d  = rem2 - trial;
          root_d = {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_d  = rem2;
          root_d = {root_q[RootW-2:0], 1'b0};
        end
        if (rcnt_q == RootCntW'(RootW - 1)) begin
          ph_d    = 1'b0;
          state_d = S_FNUM;
        end
      end

      S_FNUM: begin
        mul_req.start = !issued_q;
        mul_req.a     = MagW'(absw(g_q));
        mul_req.b     = ph_q ? MagW'(mass_q) : MagW'(srcm_q);
        issued_d      = 1'b1;
        if (issued_q && mul_done) begin
          issued_d = 1'b0;
          ph_d     = !ph_q;
          if (ph_q) begin
            nsrc_d  = mul_prod;
            state_d = S_FDIV;
          end else begin
            nown_d = mul_prod;
          end
        end
      end

      S_FDIV: begin
        div_req.start = !issued_q;
        div_req.num   = NumW'({(ph_q ? nsrc_q : nown_q), FracBits'(0)});
        div_req.den   = s_q;
        issued_d      = 1'b1;
        if (issued_q && div_done) begin
          issued_d = 1'b0;
          ph_d     = !ph_q;
          if (ph_q) begin
            fsrc_d  = sat_lim(gneg, div_quot);
            ax_d    = '0;
            state_d = S_UDIV;
          end else begin
            fown_d = sat_lim(gneg, div_quot);
          end
        end
      end

      S_UDIV: begin
        div_req.start = !issued_q;
        div_req.num   = NumW'({dmag_q[ax_q], FracBits'(0)});
        div_req.den   = ProdW'(root_q);
        issued_d      = 1'b1;
        if (issued_q && div_done) begin
          issued_d     = 1'b0;
          umag_d[ax_q] = sat_lim(dneg_q[ax_q], div_quot);
          if (ax_q == 2'd2) begin
            ax_d    = '0;
            ph_d    = 1'b0;
            state_d = S_QMUL;
          end else begin
            ax_d = ax_q + 2'd1;
          end
        end
      end

      S_QMUL: begin
        mul_req.start = !issued_q;
        mul_req.a     = MagW'(ph_q ? fsrc_q : fown_q);
        mul_req.b     = MagW'(umag_q[ax_q]);
        issued_d      = 1'b1;
        if (issued_q && mul_done) begin
          issued_d = 1'b0;
          ph_d     = !ph_q;
          if (ph_q) begin
            react_d[ax_q] = qval[WordBits-1:0];
            if (ax_q == 2'd2) begin
              dist_d  = (root_q > RootW'(UMax)) ? UMax : root_q[WordBits-2:0];
              state_d = S_DONE;
            end else begin
              ax_d = ax_q + 2'd1;
            end
          end else begin
            acc_d[ax_q] = clampw($signed({acc_q[ax_q][WordBits-1], acc_q[ax_q]}) - qval);
          end
        end
      end

      S_ADV: begin
        mul_req.start = !issued_q;
        mul_req.a     = ph_q ? MagW'(absw(vel_q[ax_q])) : MagW'(t_q);
        mul_req.b     = ph_q ? MagW'(t_q) : MagW'(absw(acc_q[ax_q]));
        issued_d      = 1'b1;
        if (issued_q && mul_done) begin
          issued_d = 1'b0;
          ph_d     = !ph_q;
          if (ph_q) begin
            // bounce off the box walls
            if (pos_new[WordBits-1]) begin
              pos_d[ax_q] = '0;
              vel_d[ax_q] = clampw(-$signed({vel_q[ax_q][WordBits-1], vel_q[ax_q]}));
            end else if ($signed(pos_new) > $signed({1'b0, bnd_q[ax_q]})) begin
              pos_d[ax_q] = {1'b0, bnd_q[ax_q]};
              vel_d[ax_q] = clampw(-$signed({vel_q[ax_q][WordBits-1], vel_q[ax_q]}));
            end else begin
              pos_d[ax_q] = pos_new;
            end
            acc_d[ax_q] = '0;
            if (ax_q == 2'd2) begin
              state_d = S_DONE;
            end else begin
              ax_d = ax_q + 2'd1;
            end
          end else begin
            vel_d[ax_q] = vel_new;
          end
        end
      end

      S_DONE: begin
        if (!res_vld_q || out_o.ready) begin
          res_d.pos_out_x     = pos_q[0];
          res_d.pos_out_y     = pos_q[1];
          res_d.pos_out_z     = pos_q[2];
          res_d.vel_out_x     = vel_q[0];
          res_d.vel_out_y     = vel_q[1];
          res_d.vel_out_z     = vel_q[2];
          res_d.react_x       = react_q[0];
          res_d.react_y       = react_q[1];
          res_d.react_z       = react_q[2];
          res_d.pair_distance = dist_q;
          res_vld_d           = 1'b1;
          state_d             = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      issued_q  <= 1'b0;
      ax_q      <= '0;
      ph_q      <= 1'b0;
      rcnt_q    <= '0;
      res_vld_q <= 1'b0;
      mass_q    <= '0;
      g_q       <= WordBits'(65536);
      mind_q    <= (WordBits-1)'(65536);
      for (int k = 0; k < 3; k++) begin
        pos_q[k] <= '0;
        vel_q[k] <= '0;
        acc_q[k] <= '0;
        bnd_q[k] <= (WordBits-1)'(65536000);
      end
    end else begin
      state_q   <= state_d;
      issued_q  <= issued_d;
      ax_q      <= ax_d;
      ph_q      <= ph_d;
      rcnt_q    <= rcnt_d;
      res_vld_q <= res_vld_d;
      mass_q    <= mass_d;
      g_q       <= g_d;
      mind_q    <= mind_d;
      pos_q     <= pos_d;
      vel_q     <= vel_d;
      acc_q     <= acc_d;
      bnd_q     <= bnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dneg_q  <= dneg_d;
    dmag_q  <= dmag_d;
    srcm_q  <= srcm_d;
    t_q     <= t_d;
    s_q     <= s_d;
    ssh_q   <= ssh_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    nown_q  <= nown_d;
    nsrc_q  <= nsrc_d;
    fown_q  <= fown_d;
    fsrc_q  <= fsrc_d;
    umag_q  <= umag_d;
    react_q <= react_d;
    dist_q  <= dist_d;
    res_q   <= res_d;
  end

  `GPU_ASSERT(a_busy_after_accept, in_i.valid && in_i.ready |=> !in_i.ready, "ready after accept")
  `GPU_ASSERT(a_mul_done_issued, mul_done |-> issued_q, "multiplier result not awaited")
  `GPU_ASSERT_NEVER(a_units_overlap, mul_done && div_done, "multiplier and divider overlap")
  `GPU_ASSERT(a_result_from_done, $rose(out_o.valid) |-> $past(state_q == S_DONE), "stray result")

endmodule
